// ===== rtl/ecp_pkg.sv =====
// shared types, constants and a saturation helper for the conserved-to-primitive block
package ecp_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int ERR_W     = 2;
    localparam int PRESS_LAT = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GAMMA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PFLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DFLOOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUAL   = 2'd3;

    localparam logic [CFG_W-1:0] GAMMA_RST  = 31'd43691;
    localparam logic [CFG_W-1:0] PFLOOR_RST = 31'd1;
    localparam logic [CFG_W-1:0] DFLOOR_RST = 31'd1;

    typedef struct packed {
        logic [CFG_W-1:0] gamma_m1;
        logic [CFG_W-1:0] p_floor;
        logic [CFG_W-1:0] d_floor;
        logic             dual;
    } t_cfg;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [71:0] x);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = 72'sh7FFFFFFF;
        lo = -72'sh80000000;
        if (x > hi) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (x < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = x[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/ecp_div.sv =====
// pipelined restoring divider: saturated (num << frac) / den, one quotient bit per stage
module ecp_div
    import ecp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W-1:0] i_den,
    output logic signed [DATA_W-1:0] o_quo
);

    localparam int NW = DATA_W + FRAC_BITS;

    logic [NW-1:0]     r_num  [0:NW];
    logic [DATA_W-1:0] r_rem  [0:NW];
    logic [DATA_W-1:0] r_den  [0:NW];
    logic              r_neg  [0:NW];
    logic              r_zero [0:NW];
    logic signed [DATA_W-1:0] r_quo;

    logic [DATA_W:0] nabs;
    logic [DATA_W:0] dabs;

    always_comb begin
        nabs = i_num[DATA_W-1] ? (33'd0 - {i_num[DATA_W-1], i_num}) : {1'b0, i_num};
        dabs = i_den[DATA_W-1] ? (33'd0 - {i_den[DATA_W-1], i_den}) : {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        r_num[0]  <= {nabs[DATA_W-1:0], {FRAC_BITS{1'b0}}};
        r_rem[0]  <= '0;
        r_den[0]  <= dabs[DATA_W-1:0];
        r_neg[0]  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
        r_zero[0] <= (i_den == '0);
    end

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DATA_W:0] trial;
        logic            qbit;
        always_comb begin
            trial = {r_rem[k], r_num[k][NW-1]};
            qbit  = (trial >= {1'b0, r_den[k]});
        end
        always_ff @(posedge i_clk) begin
            r_num[k+1]  <= {r_num[k][NW-2:0], qbit};
            r_rem[k+1]  <= qbit ? DATA_W'(trial - {1'b0, r_den[k]}) : trial[DATA_W-1:0];
            r_den[k+1]  <= r_den[k];
            r_neg[k+1]  <= r_neg[k];
            r_zero[k+1] <= r_zero[k];
        end
    end

    logic signed [DATA_W-1:0] n_quo;
    logic [NW-1:0] mag;

    always_comb begin
        mag = r_num[NW];
        if (r_zero[NW]) begin
            n_quo = '0;
        end else if (r_neg[NW]) begin
            if (mag > NW'(33'h080000000)) begin
                n_quo = 32'sh80000000;
            end else begin
                n_quo = 32'sd0 - $signed(mag[DATA_W-1:0]);
            end
        end else begin
            if (mag > NW'(33'h07FFFFFFF)) begin
                n_quo = 32'sh7FFFFFFF;
            end else begin
                n_quo = $signed(mag[DATA_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
    end

    assign o_quo = r_quo;

endmodule

// ===== rtl/ecp_press.sv =====
// pressure and density pipeline: kinetic energy, gamma scaling and floor corrections
module ecp_press
    import ecp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  t_cfg                     i_cfg,
    input  logic signed [DATA_W-1:0] i_vel_x,
    input  logic signed [DATA_W-1:0] i_vel_y,
    input  logic signed [DATA_W-1:0] i_vel_z,
    input  logic signed [DATA_W-1:0] i_rho,
    input  logic signed [DATA_W-1:0] i_energy,
    input  logic signed [DATA_W-1:0] i_eint,
    output logic signed [DATA_W-1:0] o_prim_density,
    output logic signed [DATA_W-1:0] o_gas_pressure,
    output logic signed [DATA_W-1:0] o_eint_pressure,
    output logic [ERR_W-1:0]         o_error_count
);

    // stage 1: squares
    logic signed [63:0] r_sq [0:2];
    logic signed [DATA_W-1:0] r1_rho, r1_e, r1_ei;
    always_ff @(posedge i_clk) begin
        r_sq[0] <= i_vel_x * i_vel_x;
        r_sq[1] <= i_vel_y * i_vel_y;
        r_sq[2] <= i_vel_z * i_vel_z;
        r1_rho  <= i_rho;
        r1_e    <= i_energy;
        r1_ei   <= i_eint;
    end

    // stage 2: sum of scaled squares, clamped to 32 unsigned bits
    logic [65:0] vsum;
    logic [DATA_W-1:0] r2_vsq;
    logic signed [DATA_W-1:0] r2_rho, r2_e, r2_ei;
    always_comb begin
        vsum = 66'(r_sq[0] >>> FRAC_BITS) + 66'(r_sq[1] >>> FRAC_BITS)
             + 66'(r_sq[2] >>> FRAC_BITS);
    end
    always_ff @(posedge i_clk) begin
        r2_vsq <= (vsum > 66'hFFFFFFFF) ? 32'hFFFFFFFF : vsum[DATA_W-1:0];
        r2_rho <= r1_rho;
        r2_e   <= r1_e;
        r2_ei  <= r1_ei;
    end

    // stage 3: density times squared speed
    logic signed [64:0] r3_kp;
    logic signed [DATA_W-1:0] r3_rho, r3_e, r3_ei;
    always_ff @(posedge i_clk) begin
        r3_kp  <= 65'(r2_rho) * $signed({1'b0, r2_vsq});
        r3_rho <= r2_rho;
        r3_e   <= r2_e;
        r3_ei  <= r2_ei;
    end

    // stage 4: kinetic energy density
    logic signed [DATA_W-1:0] r4_ke, r4_rho, r4_e, r4_ei;
    always_ff @(posedge i_clk) begin
        r4_ke  <= sat32(72'(r3_kp >>> (FRAC_BITS + 1)));
        r4_rho <= r3_rho;
        r4_e   <= r3_e;
        r4_ei  <= r3_ei;
    end

    // stage 5: energy operand for the gas pressure
    logic signed [DATA_W-1:0] r5_x, r5_rho, r5_ei;
    always_ff @(posedge i_clk) begin
        r5_x   <= i_cfg.dual ? sat32(72'(33'(r4_e) - 33'(r4_ke))) : r4_e;
        r5_rho <= r4_rho;
        r5_ei  <= r4_ei;
    end

    // stage 6: gamma products
    logic signed [63:0] r6_pg, r6_pe;
    logic signed [DATA_W-1:0] r6_rho;
    logic signed [DATA_W-1:0] gam;
    assign gam = $signed({1'b0, i_cfg.gamma_m1});
    always_ff @(posedge i_clk) begin
        r6_pg  <= gam * r5_x;
        r6_pe  <= gam * r5_ei;
        r6_rho <= r5_rho;
    end

    // stage 7: rescale
    logic signed [DATA_W-1:0] r7_pg, r7_pe, r7_rho;
    always_ff @(posedge i_clk) begin
        r7_pg  <= sat32(72'(r6_pg >>> FRAC_BITS));
        r7_pe  <= sat32(72'(r6_pe >>> FRAC_BITS));
        r7_rho <= r6_rho;
    end

    // stage 8: floor corrections and error count
    logic signed [DATA_W-1:0] pflr, dflr;
    logic signed [DATA_W-1:0] n_pg, n_pe, n_dens;
    logic [ERR_W-1:0] n_err;
    logic signed [DATA_W-1:0] r8_pg, r8_pe, r8_dens;
    logic [ERR_W-1:0] r8_err;

    always_comb begin
        pflr   = $signed({1'b0, i_cfg.p_floor});
        dflr   = $signed({1'b0, i_cfg.d_floor});
        n_pg   = r7_pg;
        n_pe   = r7_pe;
        n_dens = r7_rho;
        n_err  = '0;
        if (i_cfg.dual) begin
            if (r7_pe <= 0) begin
                n_pe  = (r7_pg > pflr) ? r7_pg : pflr;
                n_err = n_err + 1'b1;
            end
            if (r7_pg <= 0) begin
                n_pg = n_pe;
            end
        end else begin
            if (r7_pg <= 0) begin
                n_pg  = pflr;
                n_err = n_err + 1'b1;
            end
            n_pe = n_pg;
        end
        if (r7_rho <= 0) begin
            n_dens = dflr;
            n_err  = n_err + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_pg   <= n_pg;
        r8_pe   <= n_pe;
        r8_dens <= n_dens;
        r8_err  <= n_err;
    end

    assign o_prim_density  = r8_dens;
    assign o_gas_pressure  = r8_pg;
    assign o_eint_pressure = r8_pe;
    assign o_error_count   = r8_err;

endmodule

// ===== rtl/euler_conserved_to_primitive.sv =====
// top level: conserved-to-primitive conversion for one gas cell per clock
// Takes one cell per cycle while busy stays low (it never rises), and gives its
// primitive variables with o_valid high for one cycle. The latency is set by the
// velocity dividers, which resolve one quotient bit per stage over 32 + FRAC_BITS
// stages, followed by an eight-stage pressure pipeline. The receiver cannot stall
// the output. Configuration registers may only be written while no request is
// in flight.
module euler_conserved_to_primitive
    import ecp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_cons_density,
    input  logic signed [DATA_W-1:0] i_mom_x,
    input  logic signed [DATA_W-1:0] i_mom_y,
    input  logic signed [DATA_W-1:0] i_mom_z,
    input  logic signed [DATA_W-1:0] i_energy,
    input  logic signed [DATA_W-1:0] i_extra_internal_energy,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_prim_density,
    output logic signed [DATA_W-1:0] o_vel_x,
    output logic signed [DATA_W-1:0] o_vel_y,
    output logic signed [DATA_W-1:0] o_vel_z,
    output logic signed [DATA_W-1:0] o_gas_pressure,
    output logic signed [DATA_W-1:0] o_eint_pressure,
    output logic [ERR_W-1:0]         o_error_count
);

    localparam int DIV_LAT = DATA_W + FRAC_BITS + 2;
    localparam int TOT_LAT = DIV_LAT + PRESS_LAT;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gamma_m1 <= GAMMA_RST;
            r_cfg.p_floor  <= PFLOOR_RST;
            r_cfg.d_floor  <= DFLOOR_RST;
            r_cfg.dual     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAMMA:  r_cfg.gamma_m1 <= i_cfg_data;
                REG_PFLOOR: r_cfg.p_floor  <= i_cfg_data;
                REG_DFLOOR: r_cfg.d_floor  <= i_cfg_data;
                REG_DUAL:   r_cfg.dual     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // velocity dividers
    logic signed [DATA_W-1:0] vel_x, vel_y, vel_z;

    ecp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk(i_clk), .i_num(i_mom_x), .i_den(i_cons_density), .o_quo(vel_x)
    );
    ecp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk(i_clk), .i_num(i_mom_y), .i_den(i_cons_density), .o_quo(vel_y)
    );
    ecp_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .i_clk(i_clk), .i_num(i_mom_z), .i_den(i_cons_density), .o_quo(vel_z)
    );

    // scalar fields ride alongside the dividers
    logic signed [DATA_W-1:0] r_rho_d [0:DIV_LAT-1];
    logic signed [DATA_W-1:0] r_e_d   [0:DIV_LAT-1];
    logic signed [DATA_W-1:0] r_ei_d  [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        r_rho_d[0] <= i_cons_density;
        r_e_d[0]   <= i_energy;
        r_ei_d[0]  <= i_extra_internal_energy;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_rho_d[k] <= r_rho_d[k-1];
            r_e_d[k]   <= r_e_d[k-1];
            r_ei_d[k]  <= r_ei_d[k-1];
        end
    end

    // velocities held over the pressure stages
    logic signed [DATA_W-1:0] r_vx_d [0:PRESS_LAT-1];
    logic signed [DATA_W-1:0] r_vy_d [0:PRESS_LAT-1];
    logic signed [DATA_W-1:0] r_vz_d [0:PRESS_LAT-1];

    always_ff @(posedge i_clk) begin
        r_vx_d[0] <= vel_x;
        r_vy_d[0] <= vel_y;
        r_vz_d[0] <= vel_z;
        for (int k = 1; k < PRESS_LAT; k++) begin
            r_vx_d[k] <= r_vx_d[k-1];
            r_vy_d[k] <= r_vy_d[k-1];
            r_vz_d[k] <= r_vz_d[k-1];
        end
    end

    ecp_press #(.FRAC_BITS(FRAC_BITS)) u_press (
        .i_clk          (i_clk),
        .i_cfg          (r_cfg),
        .i_vel_x        (vel_x),
        .i_vel_y        (vel_y),
        .i_vel_z        (vel_z),
        .i_rho          (r_rho_d[DIV_LAT-1]),
        .i_energy       (r_e_d[DIV_LAT-1]),
        .i_eint         (r_ei_d[DIV_LAT-1]),
        .o_prim_density (o_prim_density),
        .o_gas_pressure (o_gas_pressure),
        .o_eint_pressure(o_eint_pressure),
        .o_error_count  (o_error_count)
    );

    // request valid marker
    logic [TOT_LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOT_LAT-2:0], start & ~busy};
        end
    end

    assign o_valid = r_vld[TOT_LAT-1];
    assign o_vel_x = r_vx_d[PRESS_LAT-1];
    assign o_vel_y = r_vy_d[PRESS_LAT-1];
    assign o_vel_z = r_vz_d[PRESS_LAT-1];

endmodule

// ===== rtl/ecp_checker.sv =====
// port-level checks for the conserved-to-primitive block, bound to the top level
module ecp_checker
    import ecp_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     busy,
    input logic                     o_valid,
    input logic signed [DATA_W-1:0] o_prim_density,
    input logic signed [DATA_W-1:0] o_gas_pressure,
    input logic signed [DATA_W-1:0] o_eint_pressure,
    input logic [ERR_W-1:0]         o_error_count
);

    // no results straight after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // corrected values are never negative
    a_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_prim_density[DATA_W-1] && !o_gas_pressure[DATA_W-1]
                     && !o_eint_pressure[DATA_W-1]))
        else $error("negative corrected output");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error_count != 2'd3))
        else $error("error count out of range");

endmodule

bind euler_conserved_to_primitive ecp_checker u_ecp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_prim_density (o_prim_density),
    .o_gas_pressure (o_gas_pressure),
    .o_eint_pressure(o_eint_pressure),
    .o_error_count  (o_error_count)
);
